// File: sv/ordered_integer_list_table_macros.svh
// assertion macros used by the checker file
`ifndef ORDERED_INTEGER_LIST_TABLE_MACROS_SVH
`define ORDERED_INTEGER_LIST_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OILT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oilt assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define OILT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oilt assertion failed");

`endif

// File: sv/oilt_pkg.sv
// shared types and constants of the ordered integer list table
`default_nettype none

package oilt_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int KIND_W           = 3;
    localparam int POS_W            = 6;
    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 2;
    localparam int IDX_OUT_W        = 6;
    localparam int CNT_OUT_W        = 7;
    localparam int S_TDATA_W        = 40;
    localparam int M_TDATA_W        = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_FIND   = 3'd3,
        KIND_GET    = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE    = 1'b0,
        ST_RESOLVE = 1'b1
    } state_t;

    // broadcast to every cell; each do_* is already qualified by a successful transaction
    typedef struct packed {
        logic step;
        logic do_append;
        logic do_insert;
        logic do_delete;
        logic do_find;
        logic do_get;
    } cell_ops_t;

endpackage

`default_nettype wire

// File: sv/oilt_cell.sv
// one list entry with its neighbor shift paths and its match flag
`default_nettype none

module oilt_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = 7
) (
    input  wire                                   clk,
    input  wire oilt_pkg::cell_ops_t              ops,
    input  wire        [CMP_W-1:0]                pos,
    input  wire        [CMP_W-1:0]                cnt,
    input  wire signed [oilt_pkg::VALUE_W-1:0]    value,
    input  wire signed [oilt_pkg::VALUE_W-1:0]    left_entry,
    input  wire signed [oilt_pkg::VALUE_W-1:0]    right_entry,
    output logic signed [oilt_pkg::VALUE_W-1:0]   entry,
    output logic                                  hit
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic signed [oilt_pkg::VALUE_W-1:0] entry_reg;
    logic signed [oilt_pkg::VALUE_W-1:0] entry_next;
    logic                                hit_reg;
    logic                                hit_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ops.do_append && (MY_IDX == cnt))
        begin
            entry_next = value;
        end
        else if (ops.do_insert)
        begin
            if (MY_IDX == pos)
            begin
                entry_next = value;
            end
            else if (MY_IDX > pos)
            begin
                entry_next = left_entry;
            end
        end
        else if (ops.do_delete && (MY_IDX >= pos))
        begin
            entry_next = right_entry;
        end
    end

    always_comb
    begin
        hit_next = 1'b0;
        if (ops.do_find)
        begin
            hit_next = (entry_reg == value) && (MY_IDX < cnt);
        end
        else if (ops.do_get)
        begin
            hit_next = (MY_IDX == pos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops.step)
        begin
            entry_reg <= entry_next;
            hit_reg   <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

// File: sv/oilt_prio.sv
// lowest-set-bit encoder built as a binary tree
`default_nettype none

module oilt_prio #(
    parameter int N = 64
) (
    input  wire  [N-1:0]         req,
    output logic                 any,
    output logic [$clog2(N)-1:0] idx
);

    localparam int IW = $clog2(N);
    localparam int NP = 1 << IW;

    // heap order: node 1 is the root, leaves sit at NP .. 2*NP-1
    logic          node_v  [0:2*NP-1];
    logic [IW-1:0] node_ix [0:2*NP-1];

    assign node_v[0]  = 1'b0;
    assign node_ix[0] = '0;

    for (genvar k = 0; k < NP; k++)
    begin : g_leaf
        if (k < N)
        begin : g_used
            assign node_v[NP+k] = req[k];
        end
        else
        begin : g_pad
            assign node_v[NP+k] = 1'b0;
        end
        assign node_ix[NP+k] = IW'(k);
    end

    for (genvar n = 1; n < NP; n++)
    begin : g_node
        assign node_v[n]  = node_v[2*n] | node_v[2*n+1];
        assign node_ix[n] = node_v[2*n] ? node_ix[2*n] : node_ix[2*n+1];
    end

    assign any = node_v[1];
    assign idx = node_ix[1];

endmodule

`default_nettype wire

// File: sv/ordered_integer_list_table.sv
// ordered integer list table: top level with control, cell row and result register
//
//   channel   dir   signals                          contents
//   s_axis    in    s_tvalid s_tready s_tdata s_tuser  operation request
//   m_axis    out   m_tvalid m_tready m_tdata m_tuser  one result per request
//
// on the accepting edge an operation updates the cell row and latches per-cell
// match flags; in the resolve state the flags are encoded into the result register.
// the row of CAPACITY cells shifts, writes and compares in parallel, so the
// time does not depend on the list length.
// rst_n clears the entry count, the control state and the result valid; entries
// hold garbage until written. a stalled result blocks the next request.
`default_nettype none

module ordered_integer_list_table #(
    parameter int CAPACITY = oilt_pkg::DEFAULT_CAPACITY
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [5:0] position, [37:6] value, [39:38] zero
    input  wire  [oilt_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] kind
    input  wire  [oilt_pkg::KIND_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [31:0] data, [32] found, [38:33] found_index, [45:39] count, [47:46] zero
    output logic [oilt_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [oilt_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > oilt_pkg::POS_W) ? CNT_W : oilt_pkg::POS_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    oilt_pkg::state_t  state_reg;
    oilt_pkg::state_t  state_next;
    oilt_pkg::kind_t   kind_in;
    oilt_pkg::status_t status_reg;
    oilt_pkg::status_t status_next;
    oilt_pkg::cell_ops_t ops;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             find_reg;
    logic             find_next;
    logic             get_reg;
    logic             get_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             in_fire;
    logic             load_out;

    logic        [oilt_pkg::POS_W-1:0]   in_pos;
    logic signed [oilt_pkg::VALUE_W-1:0] in_value;
    logic        [CMP_W-1:0]             pos_ext;
    logic        [CMP_W-1:0]             cnt_ext;

    logic signed [oilt_pkg::VALUE_W-1:0] cell_entry [0:CAPACITY-1];
    logic        [CAPACITY-1:0]          hit_vec;
    logic                                hit_any;
    logic        [IDX_W-1:0]             hit_idx;
    logic signed [oilt_pkg::VALUE_W-1:0] get_data;

    logic signed [oilt_pkg::VALUE_W-1:0]   out_data_reg;
    logic signed [oilt_pkg::VALUE_W-1:0]   out_data_next;
    logic                                  out_found_reg;
    logic                                  out_found_next;
    logic        [oilt_pkg::IDX_OUT_W-1:0] out_idx_reg;
    logic        [oilt_pkg::IDX_OUT_W-1:0] out_idx_next;
    logic        [oilt_pkg::CNT_OUT_W-1:0] out_cnt_reg;
    logic        [oilt_pkg::STATUS_W-1:0]  out_status_reg;

    assign in_pos   = s_tdata[oilt_pkg::POS_W-1:0];
    assign in_value = s_tdata[oilt_pkg::POS_W +: oilt_pkg::VALUE_W];
    assign kind_in  = oilt_pkg::kind_t'(s_tuser);
    assign pos_ext  = CMP_W'(in_pos);
    assign cnt_ext  = CMP_W'(count_reg);
    assign in_fire  = s_tvalid && s_tready;

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oilt_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = oilt_pkg::ST_RESOLVE;
                end
            end
            oilt_pkg::ST_RESOLVE:
            begin
                state_next = oilt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = oilt_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            oilt_pkg::ST_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready;
            end
            oilt_pkg::ST_RESOLVE:
            begin
                load_out = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // request decode: status, new count and cell commands
    always_comb
    begin
        status_next = oilt_pkg::STATUS_OK;
        count_next  = count_reg;
        ops         = '0;
        ops.step    = in_fire;
        find_next   = 1'b0;
        get_next    = 1'b0;
        unique case (kind_in)
            oilt_pkg::KIND_APPEND:
            begin
                if (count_reg == CNT_FULL)
                begin
                    status_next = oilt_pkg::STATUS_FULL;
                end
                else
                begin
                    ops.do_append = in_fire;
                    count_next    = count_reg + 1'b1;
                end
            end
            oilt_pkg::KIND_INSERT:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = oilt_pkg::STATUS_RANGE;
                end
                else if (count_reg == CNT_FULL)
                begin
                    status_next = oilt_pkg::STATUS_FULL;
                end
                else
                begin
                    ops.do_insert = in_fire;
                    count_next    = count_reg + 1'b1;
                end
            end
            oilt_pkg::KIND_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = oilt_pkg::STATUS_RANGE;
                end
                else
                begin
                    ops.do_delete = in_fire;
                    count_next    = count_reg - 1'b1;
                end
            end
            oilt_pkg::KIND_FIND:
            begin
                ops.do_find = in_fire;
                find_next   = 1'b1;
            end
            oilt_pkg::KIND_GET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = oilt_pkg::STATUS_RANGE;
                end
                else
                begin
                    ops.do_get = in_fire;
                    get_next   = 1'b1;
                end
            end
            default:
            begin
                status_next = oilt_pkg::STATUS_OK;
            end
        endcase
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [oilt_pkg::VALUE_W-1:0] left_w;
        logic signed [oilt_pkg::VALUE_W-1:0] right_w;

        if (k == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = cell_entry[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = cell_entry[k+1];
        end

        oilt_cell #(
            .INDEX (k),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk         (clk),
            .ops         (ops),
            .pos         (pos_ext),
            .cnt         (cnt_ext),
            .value       (in_value),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (cell_entry[k]),
            .hit         (hit_vec[k])
        );
    end

    oilt_prio #(
        .N (CAPACITY)
    ) u_prio (
        .req (hit_vec),
        .any (hit_any),
        .idx (hit_idx)
    );

    // a get leaves exactly one flag set, so an or of masked entries selects it
    always_comb
    begin
        get_data = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            get_data = get_data | (hit_vec[k] ? cell_entry[k] : '0);
        end
    end

    always_comb
    begin
        out_found_next = find_reg && hit_any;
        out_idx_next   = out_found_next ? oilt_pkg::IDX_OUT_W'(hit_idx) : '0;
        out_data_next  = get_reg ? get_data : '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oilt_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            find_reg      <= 1'b0;
            get_reg       <= 1'b0;
            status_reg    <= oilt_pkg::STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                count_reg  <= count_next;
                find_reg   <= find_next;
                get_reg    <= get_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg   <= out_data_next;
            out_found_reg  <= out_found_next;
            out_idx_reg    <= out_idx_next;
            out_cnt_reg    <= oilt_pkg::CNT_OUT_W'(count_reg);
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_cnt_reg, out_idx_reg, out_found_reg, out_data_reg};

endmodule

`default_nettype wire

// File: sv/ordered_integer_list_table_checker.sv
// port-level checker for the ordered integer list table, bound to the top level
`default_nettype none

`include "ordered_integer_list_table_macros.svh"

module ordered_integer_list_table_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire [oilt_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire [oilt_pkg::KIND_W-1:0]      s_tuser,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [oilt_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire [oilt_pkg::STATUS_W-1:0]    m_tuser
);

    // no request is taken in the cycle after a transaction, while that one is resolved
    `OILT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // a held result blocks new requests
    `OILT_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)

    // a held result keeps its contents
    `OILT_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // find never reports a match together with an error, nor an index without a match
    `OILT_ASSERT_NOW(a_found_consistent, m_tvalid,
        (m_tdata[32] && m_tuser == oilt_pkg::STATUS_OK) ||
        (!m_tdata[32] && m_tdata[38:33] == 6'd0))

endmodule

bind ordered_integer_list_table ordered_integer_list_table_checker u_checker (.*);

`default_nettype wire

// File: test/ordered_integer_list_table_tb.sv
// testbench for the ordered integer list table: queued stimulus, own list predictor, field checks
`default_nettype none

module ordered_integer_list_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oilt_pkg::*;

    localparam int LIST_DEPTH = DEFAULT_CAPACITY;
    localparam int IDLE_PCT   = 27;
    localparam int CALM_FROM  = 500;
    localparam int CALM_TO    = 720;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
    } list_op_t;

    typedef struct {
        status_t              status;
        logic [VALUE_W-1:0]   data;
        logic                 found;
        logic [IDX_OUT_W-1:0] found_index;
        logic [CNT_OUT_W-1:0] count;
    } list_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    // [5:0] position, [37:6] value, [39:38] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [2:0] kind
    logic [KIND_W-1:0]    s_tuser  = '0;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    // [31:0] data, [32] found, [38:33] found_index, [45:39] count, [47:46] zero
    wire  [M_TDATA_W-1:0] m_tdata;
    // [1:0] status
    wire  [STATUS_W-1:0]  m_tuser;

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];

    // predictor copy of the list
    logic [VALUE_W-1:0] list_vals[LIST_DEPTH];
    int                 list_len = 0;

    // length as seen by the stimulus generator, used to aim positions
    int gen_len = 0;

    int accepted_ops = 0;
    int fail_count   = 0;

    logic [VALUE_W-1:0] value_pool[8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                          32'hffff_ffff, 32'h0000_0001, 32'h5555_5555,
                                          32'haaaa_aaaa, 32'h1234_5678};

    ordered_integer_list_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic bit take_break();
        if (accepted_ops >= CALM_FROM && accepted_ops < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic list_result_t apply_list_op(logic [KIND_W-1:0] op,
                                                   logic [POS_W-1:0] pos,
                                                   logic [VALUE_W-1:0] value);
        list_result_t r;
        r.status      = STATUS_OK;
        r.data        = '0;
        r.found       = 1'b0;
        r.found_index = '0;
        case (op)
            KIND_APPEND:
                if (list_len >= LIST_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    list_vals[list_len] = value;
                    list_len++;
                end
            KIND_INSERT:
                if (int'(pos) >= list_len)
                    r.status = STATUS_RANGE;
                else if (list_len >= LIST_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    for (int i = list_len; i > int'(pos); i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[pos] = value;
                    list_len++;
                end
            KIND_DELETE:
                if (int'(pos) >= list_len)
                    r.status = STATUS_RANGE;
                else
                begin
                    for (int i = int'(pos) + 1; i < list_len; i++)
                        list_vals[i-1] = list_vals[i];
                    list_len--;
                end
            KIND_FIND:
                for (int i = 0; i < list_len; i++)
                begin
                    if (list_vals[i] == value)
                    begin
                        r.found       = 1'b1;
                        r.found_index = i[IDX_OUT_W-1:0];
                        break;
                    end
                end
            KIND_GET:
                if (int'(pos) >= list_len)
                    r.status = STATUS_RANGE;
                else
                    r.data = list_vals[pos];
            default: ;
        endcase
        r.count = list_len[CNT_OUT_W-1:0];
        return r;
    endfunction

    // queue one request and keep the generator's length estimate in step
    task automatic push_op(logic [KIND_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [VALUE_W-1:0] value);
        list_op_t item;
        item.kind  = op;
        item.pos   = pos;
        item.value = value;
        pending_ops.push_back(item);
        case (op)
            KIND_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
            KIND_INSERT: if (int'(pos) < gen_len && gen_len < LIST_DEPTH) gen_len++;
            KIND_DELETE: if (int'(pos) < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_random(int n);
        int                 r;
        int                 mode;
        logic [KIND_W-1:0]  op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            // alternate stretches that fill the list and stretches that drain it
            if (((k / 120) % 2) == 0)
                op = (r < 55) ? KIND_APPEND : (r < 70) ? KIND_INSERT : (r < 78) ? KIND_DELETE :
                     (r < 88) ? KIND_FIND : (r < 97) ? KIND_GET : KIND_W'($urandom_range(5, 7));
            else
                op = (r < 8) ? KIND_APPEND : (r < 13) ? KIND_INSERT : (r < 73) ? KIND_DELETE :
                     (r < 83) ? KIND_FIND : (r < 97) ? KIND_GET : KIND_W'($urandom_range(5, 7));
            mode = $urandom_range(0, 99);
            if (mode < 85)
                pos = (gen_len > 0) ? POS_W'($urandom_range(0, gen_len - 1)) : '0;
            else if (mode < 93 && gen_len < LIST_DEPTH)
                pos = POS_W'(gen_len);
            else
                pos = POS_W'($urandom_range(0, LIST_DEPTH - 1));
            value = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
            push_op(op, pos, value);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_ops.size() != 0 && !take_break())
            begin
                list_op_t item;
                item = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, item.value, item.pos};
                s_tuser  <= item.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !take_break();
    end

    // prediction on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_results.push_back(apply_list_op(s_tuser, s_tdata[5:0], s_tdata[37:6]));
            accepted_ops++;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            list_result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction: status %0d data %h", m_tuser,
                       m_tdata[31:0]);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tuser !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[31:0] !== exp_r.data)
                begin
                    $error("data: expected %h, actual %h", exp_r.data, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[32] !== exp_r.found)
                begin
                    $error("found: expected %0d, actual %0d", exp_r.found, m_tdata[32]);
                    fail_count++;
                end
                if (m_tdata[38:33] !== exp_r.found_index)
                begin
                    $error("found_index: expected %0d, actual %0d", exp_r.found_index,
                           m_tdata[38:33]);
                    fail_count++;
                end
                if (m_tdata[45:39] !== exp_r.count)
                begin
                    $error("count: expected %0d, actual %0d", exp_r.count, m_tdata[45:39]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every positional access is out of range, find misses
        push_op(KIND_GET,    6'd0,  32'h0000_0000);
        push_op(KIND_DELETE, 6'd0,  32'h0000_0000);
        push_op(KIND_INSERT, 6'd0,  32'h1111_1111);
        push_op(KIND_FIND,   6'd0,  32'h0000_0005);
        push_op(KIND_APPEND, 6'd63, 32'h8000_0000);
        push_op(KIND_APPEND, 6'd0,  32'h7fff_ffff);
        push_op(KIND_APPEND, 6'd0,  32'h0000_0000);
        push_op(KIND_APPEND, 6'd0,  32'hffff_ffff);
        push_op(KIND_INSERT, 6'd0,  32'h7fff_ffff);
        // insert at the end is refused
        push_op(KIND_INSERT, 6'd5,  32'h2222_2222);
        push_op(KIND_INSERT, 6'd63, 32'h3333_3333);
        // duplicate value: first match wins
        push_op(KIND_FIND,   6'd0,  32'h7fff_ffff);
        push_op(KIND_FIND,   6'd0,  32'h1234_5678);
        push_op(KIND_FIND,   6'd0,  32'h8000_0000);
        push_op(KIND_GET,    6'd4,  32'h0000_0000);
        push_op(KIND_GET,    6'd5,  32'h0000_0000);
        push_op(KIND_GET,    6'd63, 32'hffff_ffff);
        push_op(KIND_DELETE, 6'd5,  32'h0000_0000);
        push_op(KIND_DELETE, 6'd4,  32'h0000_0000);
        push_op(KIND_DELETE, 6'd0,  32'h0000_0000);
        push_op(KIND_GET,    6'd0,  32'h0000_0000);
        push_op(3'd5, 6'd2,  32'hdead_beef);
        push_op(3'd6, 6'd63, 32'hffff_ffff);
        push_op(3'd7, 6'd0,  32'h0000_0000);
        wait_drained();

        // random traffic, with the sender held off until the list side is drained in between
        push_random(420);
        wait_drained();
        push_random(420);
        wait_drained();
        push_random(430);
        wait_drained();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("ordered_integer_list_table_tb passed");
        else
            $display("ordered_integer_list_table_tb failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("ordered_integer_list_table_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
